>>> rtl/ita_pkg.sv
// Shared constants, types and helpers for the integer-to-ASCII radix unit.
package ita_pkg;

  // Input value width on the stream port and default significant bits
  localparam int VALUE_W        = 64;
  localparam int VALUE_BITS_DEF = 64;

  // Register field widths
  localparam int RADIX_W = 6;
  localparam int WIDTH_W = 5;
  localparam int CHAR_W  = 8;

  // Configuration limits and reset values
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RST   = 6'd10;
  localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = 5'd16;
  localparam logic [WIDTH_W-1:0] WIDTH_RST   = 5'd0;
  localparam logic [CHAR_W-1:0]  FILL_RST    = 8'h20;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
  localparam logic [RADIX_W-1:0] DEC_LIMIT = 6'd10;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_RADIX     = 2'd0;
  localparam logic [1:0] REG_MIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_FILL_CHAR = 2'd2;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    T_IDLE,
    T_DIV,
    T_EMIT
  } top_state_t;

  // Character emitter states
  typedef enum logic [1:0] {
    E_IDLE,
    E_PAD,
    E_READ,
    E_DATA
  } emit_state_t;

  // Divider control and status
  typedef struct packed {
    logic load;   // take a new dividend and start
    logic start;  // divide the held quotient again
  } div_ctrl_t;

  typedef struct packed {
    logic done;       // one-cycle pulse: remainder and quotient valid
    logic quot_zero;  // held quotient is zero
  } div_stat_t;

  // Digit value 0..35 to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_ALPHA + {2'b00, d - DEC_LIMIT};
    end
    return c;
  endfunction

endpackage

>>> rtl/integer_to_ascii_radix_unit.sv
// Top level of the integer-to-ASCII radix unit: registers, sequencer, divider and emitter.
//
// Converts one unsigned value per input transaction into its ASCII text in the programmed
// radix (2..36, letters from 'A' for digits of ten and up), most significant character
// first, with leading fill characters up to min_width and tlast on the final character.
// One value is handled at a time. Each digit comes out of a bit-serial divider, and the
// characters are emitted once all digits are known; a new value is accepted once the last
// character has been loaded into the output register. Digits sit in a small digit memory
// that is always written before it is read, so no clearing pass follows reset.
// Out-of-range radix and width settings saturate.
module integer_to_ascii_radix_unit #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ita_pkg::VALUE_W-1:0]  s_tdata,   // [63:0] value
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ita_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] out_char
  output logic                         m_tlast
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [ita_pkg::RADIX_W-1:0] radix;
  logic [ita_pkg::WIDTH_W-1:0] min_width;
  logic [ita_pkg::CHAR_W-1:0]  fill_char;
  logic [ita_pkg::RADIX_W-1:0] radix_eff;
  logic [ita_pkg::WIDTH_W-1:0] width_eff;
  logic                        cfg_wr;

  ita_pkg::top_state_t         state, state_next;
  logic [CW-1:0]               ndig, ndig_next;
  logic [CW-1:0]               ndig_inc;

  ita_pkg::div_ctrl_t          div_ctrl;
  ita_pkg::div_stat_t          div_st;
  logic [ita_pkg::RADIX_W-1:0] div_rem;
  logic                        dig_wr;
  logic                        emit_start;
  logic                        emit_busy;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= ita_pkg::RADIX_RST;
      min_width <= ita_pkg::WIDTH_RST;
      fill_char <= ita_pkg::FILL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ita_pkg::REG_RADIX:     radix     <= pwdata[ita_pkg::RADIX_W-1:0];
        ita_pkg::REG_MIN_WIDTH: min_width <= pwdata[ita_pkg::WIDTH_W-1:0];
        ita_pkg::REG_FILL_CHAR: fill_char <= pwdata[ita_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      ita_pkg::REG_RADIX:     prdata = 32'(radix);
      ita_pkg::REG_MIN_WIDTH: prdata = 32'(min_width);
      ita_pkg::REG_FILL_CHAR: prdata = 32'(fill_char);
      default:                prdata = '0;
    endcase
  end

  // Saturated working settings
  assign radix_eff = (radix < ita_pkg::RADIX_MIN) ? ita_pkg::RADIX_MIN :
                     (radix > ita_pkg::RADIX_MAX) ? ita_pkg::RADIX_MAX : radix;
  assign width_eff = (min_width > ita_pkg::WIDTH_LIMIT) ? ita_pkg::WIDTH_LIMIT : min_width;

  assign ndig_inc = ndig + 1'b1;

  // Sequencer: divide until the quotient is zero, then hand the run to the emitter
  always_comb begin
    state_next     = state;
    ndig_next      = ndig;
    s_tready       = 1'b0;
    div_ctrl.load  = 1'b0;
    div_ctrl.start = 1'b0;
    dig_wr         = 1'b0;
    emit_start     = 1'b0;
    unique case (state)
      ita_pkg::T_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          div_ctrl.load = 1'b1;
          ndig_next     = '0;
          state_next    = ita_pkg::T_DIV;
        end
      end
      ita_pkg::T_DIV: begin
        if (div_st.done) begin
          dig_wr    = 1'b1;
          ndig_next = ndig_inc;
          if (div_st.quot_zero) begin
            emit_start = 1'b1;
            state_next = ita_pkg::T_EMIT;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      ita_pkg::T_EMIT: begin
        if (!emit_busy) begin
          state_next = ita_pkg::T_IDLE;
        end
      end
      default: state_next = ita_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ita_pkg::T_IDLE;
      ndig  <= '0;
    end else begin
      state <= state_next;
      ndig  <= ndig_next;
    end
  end

  ita_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (div_ctrl),
    .load_value (s_tdata[VALUE_BITS-1:0]),
    .radix      (radix_eff),
    .stat       (div_st),
    .rem        (div_rem)
  );

  ita_emitter #(
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (dig_wr),
    .wr_addr    (ndig[AW-1:0]),
    .wr_digit   (div_rem),
    .start      (emit_start),
    .num_digits (ndig_inc),
    .min_width  (width_eff),
    .fill_char  (fill_char),
    .busy       (emit_busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .out_last   (m_tlast)
  );

  // Divider results only arrive while the sequencer is dividing
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ita_pkg::T_DIV)
    else $error("divider done outside divide phase");

  // Digit count never exceeds the digit memory depth
  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    ndig <= CW'(VALUE_BITS))
    else $error("digit count overflow");

  // Digit memory is not written while the emitter reads it
  a_no_wr_emit: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> !dig_wr)
    else $error("digit write during emission");

  // An accepted value starts a division
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ita_pkg::T_DIV && !emit_busy))
    else $error("accepted value did not start division");

endmodule

>>> rtl/ita_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle by the radix.
module ita_divider #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ita_pkg::div_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]        load_value,
  input  logic [ita_pkg::RADIX_W-1:0]  radix,
  output ita_pkg::div_stat_t           stat,
  output logic [ita_pkg::RADIX_W-1:0]  rem
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]       quot;
  logic [ita_pkg::RADIX_W-1:0] rmd;
  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic                        done;

  logic [ita_pkg::RADIX_W:0]   trial;
  logic                        qbit;
  logic [ita_pkg::RADIX_W:0]   trial_sub;

  // Shift the next dividend bit into the partial remainder
  assign trial     = {rmd, quot[VALUE_BITS-1]};
  assign qbit      = (trial >= {1'b0, radix});
  assign trial_sub = trial - {1'b0, radix};

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load || ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Datapath: quotient shifts left as the dividend shifts out
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quot <= load_value;
      rmd  <= '0;
    end else if (ctrl.start) begin
      rmd  <= '0;
    end else if (busy) begin
      quot <= {quot[VALUE_BITS-2:0], qbit};
      rmd  <= qbit ? trial_sub[ita_pkg::RADIX_W-1:0] : trial[ita_pkg::RADIX_W-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.quot_zero = (quot == '0);
  assign rem            = rmd;

endmodule

>>> rtl/ita_emitter.sv
// Digit store and character emitter: padding first, then digits most significant first.
module ita_emitter #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // digit writes, least significant digit at address 0
  input  logic                                wr_en,
  input  logic [$clog2(VALUE_BITS)-1:0]       wr_addr,
  input  logic [ita_pkg::RADIX_W-1:0]         wr_digit,
  // run start
  input  logic                                start,
  input  logic [$clog2(VALUE_BITS+1)-1:0]     num_digits,
  input  logic [ita_pkg::WIDTH_W-1:0]         min_width,
  input  logic [ita_pkg::CHAR_W-1:0]          fill_char,
  output logic                                busy,
  // character stream
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ita_pkg::CHAR_W-1:0]          out_char,
  output logic                                out_last
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [ita_pkg::RADIX_W-1:0] mem [VALUE_BITS];
  logic [ita_pkg::RADIX_W-1:0] rd_data;

  ita_pkg::emit_state_t        state, state_next;
  logic [ita_pkg::WIDTH_W-1:0] pad_cnt, pad_cnt_next;
  logic [AW-1:0]               dig_idx, dig_idx_next;
  logic [ita_pkg::CHAR_W-1:0]  fill_reg, fill_reg_next;
  logic                        out_valid_next;
  logic [ita_pkg::CHAR_W-1:0]  out_char_next;
  logic                        out_last_next;

  logic [CW-1:0]               width_ext;
  logic [CW-1:0]               pad_calc;
  logic [CW-1:0]               last_idx;
  logic                        out_free;

  // Digit memory, registered read at the current digit index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_digit;
    end
    rd_data <= mem[dig_idx];
  end

  assign width_ext = CW'(min_width);
  assign pad_calc  = (width_ext > num_digits) ? (width_ext - num_digits) : '0;
  assign last_idx  = num_digits - 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Next state and output register
  always_comb begin
    state_next     = state;
    pad_cnt_next   = pad_cnt;
    dig_idx_next   = dig_idx;
    fill_reg_next  = fill_reg;
    out_valid_next = out_valid && !out_ready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    unique case (state)
      ita_pkg::E_IDLE: begin
        if (start) begin
          pad_cnt_next  = pad_calc[ita_pkg::WIDTH_W-1:0];
          dig_idx_next  = last_idx[AW-1:0];
          fill_reg_next = fill_char;
          state_next    = (pad_calc != '0) ? ita_pkg::E_PAD : ita_pkg::E_READ;
        end
      end
      ita_pkg::E_PAD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = fill_reg;
          out_last_next  = 1'b0;
          pad_cnt_next   = pad_cnt - 1'b1;
          if (pad_cnt == 1) begin
            state_next = ita_pkg::E_READ;
          end
        end
      end
      ita_pkg::E_READ: begin
        state_next = ita_pkg::E_DATA;
      end
      ita_pkg::E_DATA: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = ita_pkg::digit_char(rd_data);
          out_last_next  = (dig_idx == '0);
          if (dig_idx == '0) begin
            state_next = ita_pkg::E_IDLE;
          end else begin
            dig_idx_next = dig_idx - 1'b1;
            state_next   = ita_pkg::E_READ;
          end
        end
      end
      default: state_next = ita_pkg::E_IDLE;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ita_pkg::E_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pad_cnt  <= pad_cnt_next;
    dig_idx  <= dig_idx_next;
    fill_reg <= fill_reg_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign busy = (state != ita_pkg::E_IDLE);

endmodule

>>> verif/ita_text_checker.sv
// Checker for the integer-to-ASCII radix unit: tracks config, predicts characters, compares.
`timescale 1ns / 1ps

module ita_text_checker #(
  parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [ita_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
  // output stream
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [ita_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] out_char
  input  logic                        m_tlast,
  // status to the testbench top
  output int                          fail_count,
  output int                          pending
);
  import ita_pkg::*;

  localparam logic [VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VALUE_W) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
  localparam int MAX_SHOWN = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Shadow copy of the configuration registers
  logic [RADIX_W-1:0] radix_cfg;
  logic [WIDTH_W-1:0] width_cfg;
  logic [CHAR_W-1:0]  fill_cfg;

  text_char_t text_q[$];
  int         char_count;
  int         shown;

  task automatic report_mismatch(input string what);
    if (shown < MAX_SHOWN) begin
      $display("%0t ERROR: %s", $time, what);
    end
    shown++;
    fail_count++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [VALUE_W-1:0] d);
    if (d < DEC_LIMIT) begin
      return CHAR_ZERO + d[CHAR_W-1:0];
    end
    return CHAR_ALPHA + (d[CHAR_W-1:0] - DEC_LIMIT);
  endfunction

  // Expected text of one value under the current settings, queued in output order
  function automatic void queue_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    logic [RADIX_W-1:0] r;
    logic [CHAR_W-1:0]  digits[$];  // least significant first
    int                 width;
    int                 total;
    int                 pad;
    int                 k;
    text_char_t         e;
    v = raw & VALUE_MASK;
    r = radix_cfg;
    if (r < RADIX_MIN) begin
      r = RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      r = RADIX_MAX;
    end
    base = {{(VALUE_W-RADIX_W){1'b0}}, r};
    width = (width_cfg > WIDTH_LIMIT) ? int'(WIDTH_LIMIT) : int'(width_cfg);
    // zero still yields one digit
    do begin
      digits.push_back(digit_to_char(v % base));
      v = v / base;
    end while (v != 0);
    total = (digits.size() < width) ? width : digits.size();
    pad = total - digits.size();
    for (k = 0; k < total; k++) begin
      e.ch   = (k < pad) ? fill_cfg : digits[total - 1 - k];
      e.last = (k == total - 1);
      text_q.push_back(e);
    end
  endfunction

  // Monitor: config writes, accepted values, accepted characters
  always @(posedge clk) begin
    text_char_t e;
    if (rst) begin
      radix_cfg = RADIX_RST;
      width_cfg = WIDTH_RST;
      fill_cfg  = FILL_RST;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RADIX:     radix_cfg = pwdata[RADIX_W-1:0];
          REG_MIN_WIDTH: width_cfg = pwdata[WIDTH_W-1:0];
          REG_FILL_CHAR: fill_cfg  = pwdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        queue_text(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("character %h with nothing expected", m_tdata));
        end else begin
          e = text_q.pop_front();
          if (m_tdata !== e.ch) begin
            report_mismatch($sformatf("character %0d: out_char %h, expected %h",
                                      char_count, m_tdata, e.ch));
          end
          if (m_tlast !== e.last) begin
            report_mismatch($sformatf("character %0d: last %b, expected %b",
                                      char_count, m_tlast, e.last));
          end
        end
        char_count++;
      end
    end
    pending = text_q.size();
  end

endmodule

>>> verif/tb_integer_to_ascii_radix_unit.sv
// Testbench top for the integer-to-ASCII radix unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix_unit;
  import ita_pkg::*;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          RANDOM_PHASES  = 9;
  localparam int          PHASE_ITEMS    = 20;
  localparam logic [1:0]  REG_SPARE      = 2'd3;  // unmapped register slot

  logic clk = 1'b0;
  logic rst;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  logic                s_tvalid;
  logic                s_tready;
  logic [VALUE_W-1:0]  s_tdata;   // [63:0] value
  logic                m_tvalid;
  logic                m_tready;
  logic [CHAR_W-1:0]   m_tdata;   // [7:0] out_char
  logic                m_tlast;

  int   fail_count;
  int   pending;
  int   idle_cycles;
  logic quiet;  // no idling on either side

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  integer_to_ascii_radix_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ita_text_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: cycles without any transaction on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_integer_to_ascii_radix_unit failed");
    $finish;
  end

  // Sink: random stall bursts on m_tready
  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // APB write; starts and ends at a falling edge, upper data bits are noise
  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {24'($urandom_range(0, 32'hFFFFFF)), data};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // One value transaction, optionally after an idle burst
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait for every expected character
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random value with a random significant length
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int len;
    v = {$urandom, $urandom};
    len = $urandom_range(0, VALUE_W);
    if (len < VALUE_W) begin
      v = v & ((64'd1 << len) - 64'd1);
    end
    return v;
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    rst      = 1'b1;
    quiet    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: decimal, no padding
    send_value('0);
    send_value(64'd1);
    send_value('1);
    send_value(64'd1234567890);
    finish_phase();

    // Binary, full width, NUL fill: longest runs
    write_reg(REG_RADIX, 8'd2);
    write_reg(REG_MIN_WIDTH, 8'd16);
    write_reg(REG_FILL_CHAR, 8'h00);
    send_value('0);
    send_value('1);
    send_value(64'd5);
    finish_phase();

    // Base 36 letters, all-ones fill; unmapped slot is ignored
    write_reg(REG_RADIX, 8'd36);
    write_reg(REG_MIN_WIDTH, 8'd0);
    write_reg(REG_FILL_CHAR, 8'hFF);
    write_reg(REG_SPARE, 8'h55);
    send_value(64'd35);
    send_value(64'd36);
    send_value('1);
    finish_phase();

    // Radix below two and width above the limit both saturate
    write_reg(REG_RADIX, 8'd0);
    write_reg(REG_MIN_WIDTH, 8'd31);
    write_reg(REG_FILL_CHAR, 8'h2A);
    send_value('0);
    send_value(64'd6);
    finish_phase();
    write_reg(REG_RADIX, 8'd1);
    write_reg(REG_MIN_WIDTH, 8'd17);
    send_value(64'd3);
    finish_phase();

    // Radix above 36 saturates
    write_reg(REG_RADIX, 8'd63);
    write_reg(REG_MIN_WIDTH, 8'd1);
    send_value('0);
    send_value(64'd71);
    finish_phase();
    write_reg(REG_RADIX, 8'd37);
    send_value(64'd1295);
    finish_phase();

    // Hex with zero fill
    write_reg(REG_RADIX, 8'd16);
    write_reg(REG_MIN_WIDTH, 8'd16);
    write_reg(REG_FILL_CHAR, 8'h30);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'hDEAD);
    finish_phase();

    // Random settings, mostly in range; idling stops for the last phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        quiet <= 1'b1;
      end
      write_reg(REG_RADIX, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 63))
                                                       : 8'($urandom_range(2, 36)));
      write_reg(REG_MIN_WIDTH, ($urandom_range(0, 5) == 0) ? 8'($urandom_range(17, 31))
                                                           : 8'($urandom_range(0, 16)));
      write_reg(REG_FILL_CHAR, 8'($urandom_range(0, 255)));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_value(rand_value());
      end
      finish_phase();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_integer_to_ascii_radix_unit passed");
    end else begin
      $display("tb_integer_to_ascii_radix_unit failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ita_pkg.sv
rtl/ita_divider.sv
rtl/ita_emitter.sv
rtl/integer_to_ascii_radix_unit.sv
verif/ita_text_checker.sv
verif/tb_integer_to_ascii_radix_unit.sv
